@@ sv/bis_pkg.sv @@
package bis_pkg;

  localparam int RADICAND_W = 16;
  localparam int ROOT_W     = 9;
  // Estimate register width; after the first update the estimate stays in 0..377.
  localparam int EST_W      = 9;
  localparam int QUO_W      = RADICAND_W;
  localparam int SUM_W      = QUO_W + 1;

  localparam logic [EST_W-1:0] START_EST = EST_W'(100);
  localparam logic [EST_W-1:0] EST_MAX   = EST_W'(377);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } bis_state_t;

endpackage

@@ sv/bis_in_if.sv @@
interface bis_in_if;
  logic                            valid;
  logic                            ready;
  logic [bis_pkg::RADICAND_W-1:0]  radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

@@ sv/bis_out_if.sv @@
interface bis_out_if;
  logic                        valid;
  logic                        ready;
  logic [bis_pkg::ROOT_W-1:0]  root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

@@ sv/bis_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bis_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [bis_pkg::RADICAND_W-1:0]  dividend,
  input  logic [bis_pkg::EST_W-1:0]       divisor,
  output logic                            done,
  output logic [bis_pkg::QUO_W-1:0]       quotient
);
  import bis_pkg::*;

  localparam int CntW = $clog2(QUO_W + 1);

  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [EST_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [EST_W-1:0] dvs_r, dvs_nxt;
  logic [EST_W:0]   trial;
  logic [EST_W:0]   diff;

  // next partial remainder: shift in the next dividend bit
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CntW'(QUO_W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CntW'(1);
      done_nxt = (cnt_r == CntW'(1));
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[EST_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[EST_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/babylonian_integer_sqrt.sv @@
// Per word: accept, then for each update a check, the quotient bits and the quotient
//   handoff, then a final check and the output load; at most MAX_ITERATIONS
//   updates from input accept to out valid, fewer on early stop.
// Throughput: one word at a time; the next word is taken the cycle after the result
//   is loaded, which waits while the output is held off.
// Reset: synchronous active-low rst_n clears the sequencer, the divider
//   counter and the output valid; datapath registers are not reset.
module babylonian_integer_sqrt #(
  parameter int MAX_ITERATIONS = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  bis_in_if.sink   in_s,
  bis_out_if.source out_s
);
  import bis_pkg::*;

  localparam int StepW = $clog2(MAX_ITERATIONS + 1);

  // Sequencer: IDLE takes a word, CHECK decides whether another update is due,
  // DIV waits for radicand/estimate, FIN hands the estimate to the output register.
  bis_state_t            state_r, state_nxt;
  logic [RADICAND_W-1:0] val_r, val_nxt;
  logic [EST_W-1:0]      est_r, est_nxt;     // current estimate
  logic [EST_W-1:0]      prev_r, prev_nxt;   // estimate after the previous update
  logic [StepW-1:0]      step_r, step_nxt;   // updates done so far
  logic                  out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]     out_root_r, out_root_nxt;

  logic                  div_start;
  logic                  div_done;
  logic [QUO_W-1:0]      div_quo;
  logic [SUM_W-1:0]      est_sum;
  logic [EST_W-1:0]      est_upd;

  bis_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (val_r),
    .divisor  (est_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // (est + value/est) / 2; the new estimate always fits the estimate width
  assign est_sum = SUM_W'(est_r) + SUM_W'(div_quo);
  assign est_upd = est_sum[EST_W:1];

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    est_nxt       = est_r;
    prev_nxt      = prev_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_root_nxt  = out_root_r;
    div_start     = 1'b0;

    if (out_valid_r && out_s.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_s.valid) begin
          val_nxt   = in_s.radicand;
          est_nxt   = START_EST;
          prev_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A zero estimate (radicand 0) ends the loop with root 0, which est_r holds.
        if (step_r == StepW'(MAX_ITERATIONS) || est_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          est_nxt = est_upd;
          // unchanged estimate stops the loop, but never on the first update
          if (step_r != '0 && prev_r == est_upd) begin
            state_nxt = ST_FIN;
          end else begin
            prev_nxt  = est_upd;
            step_nxt  = step_r + StepW'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FIN: begin
        // wait until the output register is free or being emptied
        if (!out_valid_r || out_s.ready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = ROOT_W'(est_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    est_r      <= est_nxt;
    prev_r     <= prev_nxt;
    step_r     <= step_nxt;
    out_root_r <= out_root_nxt;
  end

  assign in_s.ready = (state_r == ST_IDLE);
  assign out_s.valid = out_valid_r;
  assign out_s.root  = out_root_r;

  // divider finishes only while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider done outside DIV");

  // no update is started past the iteration limit
  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> step_r < StepW'(MAX_ITERATIONS))
    else $error("update started beyond iteration limit");

  // estimate stays in range during a computation
  a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK || state_r == ST_DIV) |-> est_r <= EST_MAX)
    else $error("estimate out of range");

  // a result is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_s.ready) |=> state_r == ST_FIN)
    else $error("result dropped while output full");

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  // Update limit handed to the block; the predictor uses the same value.
  localparam int UPDATE_LIMIT  = 15;
  // First guess of the iteration.
  localparam int SEED_ESTIMATE = 100;
  // Total words offered, directed rows included.
  localparam int WORD_TOTAL    = 1050;
  // Longest receiver hold-off, long enough to back the block up into its input.
  localparam int LONG_HOLD     = 1500;
  // Wait after the last owed root, long enough for stray words to show up.
  localparam int DRAIN_CYCLES  = 320;
  // Words accepted before the long receiver hold-off kicks in.
  localparam int HOLD_AFTER    = 400;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_STARVE,  // ready one cycle in ten
    RX_PULSE    // ready on a fixed 1-in-4 beat
  } rx_mode_t;

  // One row of the directed table. When pinned is set, the root is
  // typed in and used as is; otherwise the predictor supplies it.
  typedef struct packed {
    logic [RADICAND_W-1:0] radicand;
    logic                  pinned;
    logic [ROOT_W-1:0]     root;
  } sqrt_row_t;

  localparam int ROW_COUNT = 22;

  // Directed words: field extremes, the zero-estimate stop, the case where
  // the first update leaves the guess unchanged, perfect squares around
  // the seed, and bit patterns.
  sqrt_row_t directed_rows [0:ROW_COUNT-1] = '{
    '{16'd0,     1'b1, 9'd0},    // estimate halves down to zero, loop stops at zero
    '{16'd10000, 1'b1, 9'd100},  // first update unchanged, second one ends it
    '{16'd65535, 1'b0, 9'd0},    // largest radicand, biggest first jump
    '{16'd1,     1'b0, 9'd0},
    '{16'd2,     1'b0, 9'd0},
    '{16'd3,     1'b0, 9'd0},
    '{16'd4,     1'b0, 9'd0},
    '{16'd99,    1'b0, 9'd0},
    '{16'd100,   1'b0, 9'd0},
    '{16'd101,   1'b0, 9'd0},
    '{16'd255,   1'b0, 9'd0},
    '{16'd256,   1'b0, 9'd0},
    '{16'd9999,  1'b0, 9'd0},
    '{16'd10201, 1'b0, 9'd0},
    '{16'd10404, 1'b0, 9'd0},
    '{16'd32768, 1'b0, 9'd0},
    '{16'd40000, 1'b0, 9'd0},
    '{16'd65025, 1'b0, 9'd0},
    '{16'hFF00,  1'b0, 9'd0},
    '{16'h00FF,  1'b0, 9'd0},
    '{16'hAAAA,  1'b0, 9'd0},
    '{16'h5555,  1'b0, 9'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  bis_in_if  in_ch ();
  bis_out_if out_ch ();

  babylonian_integer_sqrt #(
    .MAX_ITERATIONS(UPDATE_LIMIT)
  ) dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_ch.sink),
    .out_s(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Roots still owed by the block, oldest first.
  logic [ROOT_W-1:0] pending_roots [$];
  int                mismatch_count = 0;
  int                words_accepted = 0;

  // Babylonian iteration as the block should run it: start at the seed,
  // average guess and quotient with truncation, give up at the limit.
  // A repeat only counts from the second update on; a zero guess means
  // the radicand was zero and the loop stops with root 0.
  function automatic logic [ROOT_W-1:0] babylon_estimate(input logic [RADICAND_W-1:0] value);
    int unsigned guess;
    int unsigned last_guess;
    int unsigned upd;
    guess      = SEED_ESTIMATE;
    last_guess = 0;
    for (upd = 0; upd < UPDATE_LIMIT; upd++) begin
      if (guess == 0) return '0;
      guess = (guess + value / guess) >> 1;
      if (upd > 0 && last_guess == guess) break;
      last_guess = guess;
    end
    return guess[ROOT_W-1:0];
  endfunction

  // Random radicand with weight on the regions that steer the loop:
  // small values, perfect squares and their neighbors, the seed's own
  // square where the first update stalls, and the top of the range.
  function automatic logic [RADICAND_W-1:0] pick_radicand();
    logic [RADICAND_W:0] wide;
    int unsigned         side;
    side = $urandom_range(0, 15);
    case (side)
      0, 1, 2, 3, 4, 5: begin
        wide = {1'b0, 16'($urandom())};
      end
      6, 7: begin
        wide = 17'($urandom_range(0, 400));
      end
      8, 9: begin
        side = $urandom_range(0, 255);
        wide = 17'(side * side);
      end
      10, 11: begin
        side = $urandom_range(1, 255);
        wide = 17'(side * side) + 17'($urandom_range(0, 2)) - 17'd1;
      end
      12: begin
        // radicands near the seed's square: the first update lands on the seed or one below
        wide = 17'($urandom_range(9900, 10199));
      end
      default: begin
        wide = 17'($urandom_range(60000, 65535));
      end
    endcase
    if (wide > 17'd65535) wide = 17'd65535;
    return wide[RADICAND_W-1:0];
  endfunction

  // Offer one word at the falling edge and hold it until the block takes
  // it. valid is left high so a back-to-back word needs no extra edge.
  task automatic offer_word(input logic [RADICAND_W-1:0] value, input logic pinned,
                            input logic [ROOT_W-1:0] pinned_root);
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= value;
    do @(posedge clk); while (!in_ch.ready);
    pending_roots.push_back(pinned ? pinned_root : babylon_estimate(value));
    words_accepted++;
  endtask

  // Drop valid for a number of cycles; the radicand goes to junk meanwhile
  // so nothing can lean on a stale value.
  task automatic idle_input(input int unsigned cycles);
    @(negedge clk);
    in_ch.valid    <= 1'b0;
    in_ch.radicand <= 16'($urandom());
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Gap before a burst: mostly none or short, now and then long enough to
  // let the block go idle and land the next word on any phase.
  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4:   return 0;
      15:              return $urandom_range(20, 300);
      default:         return $urandom_range(1, 8);
    endcase
  endfunction

  // Stimulus: reset, directed table, then random bursts.
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int          row;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.radicand = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    for (row = 0; row < ROW_COUNT; row++) begin
      if (burst_left == 0) begin
        gap = pick_gap();
        if (gap > 0) idle_input(gap);
        burst_left = $urandom_range(1, 6);
      end
      offer_word(directed_rows[row].radicand, directed_rows[row].pinned,
                 directed_rows[row].root);
      burst_left--;
    end

    while (words_accepted < WORD_TOTAL) begin
      if (burst_left == 0) begin
        gap = pick_gap();
        if (gap > 0) idle_input(gap);
        burst_left = $urandom_range(1, 40);
      end
      offer_word(pick_radicand(), 1'b0, '0);
      burst_left--;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait out the last roots, then give stray words a chance to show up.
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: runs spans of random length in one stall pattern each. Once,
  // well into the random part, it holds ready low for a long stretch while
  // the sender keeps offering, so the block backs up and stalls its input.
  initial begin
    rx_mode_t    mode;
    int unsigned span;
    int unsigned beat;
    bit          held_long;

    out_ch.ready = 1'b0;
    held_long    = 1'b0;
    beat         = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_long && words_accepted >= HOLD_AFTER) begin
        held_long = 1'b1;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        beat++;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_STARVE: out_ch.ready <= ($urandom_range(0, 9) == 0);
          default:   out_ch.ready <= (beat % 4 == 0);
        endcase
      end
    end
  end

  // Scoreboard: every root taken from the block must match the oldest one
  // still owed.
  always @(posedge clk) begin : check_root
    logic [ROOT_W-1:0] want_root;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_roots.size() == 0) begin
        $error("root: no word expected, actual %0d", out_ch.root);
        mismatch_count++;
      end else begin
        want_root = pending_roots.pop_front();
        if (out_ch.root !== want_root) begin
          $error("root: expected %0d, actual %0d", want_root, out_ch.root);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bis_pkg.sv
sv/bis_in_if.sv
sv/bis_out_if.sv
sv/bis_div.sv
sv/babylonian_integer_sqrt.sv
verif/tb.sv
